/* hdl/bcc_pkg.sv */
// -----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click classifier.
// -----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned CfgWidth          = 16;
  localparam int unsigned CfgIndexWidth     = 2;
  localparam int unsigned EventWidth        = 3;
  localparam int unsigned TallyWidth        = 2;

  localparam logic [CfgWidth-1:0] LongPressReset  = 16'd120;
  localparam logic [CfgWidth-1:0] ShortClickReset = 16'd40;
  localparam logic [CfgWidth-1:0] ClickGapReset   = 16'd25;
  localparam logic [CfgWidth-1:0] MinPressReset   = 16'd2;

  localparam logic [TallyWidth-1:0] TallyMax = 2'd3;

  typedef enum logic [EventWidth-1:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_TRIPLE = 3'd3,
    EV_LONG   = 3'd4
  } event_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_LONG_PRESS  = 2'd0,
    CFG_SHORT_CLICK = 2'd1,
    CFG_CLICK_GAP   = 2'd2,
    CFG_MIN_PRESS   = 2'd3
  } cfg_idx_e;

endpackage

/* hdl/button_click_classifier.sv */
// -----------------------------------------------------------------------------
// button_click_classifier
// Turns one sampled key level per tick into click and long-press events.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel: one key_down_i sample per beat (in_valid_i, in_stall_o).
//   Output channel: exactly one event_code_o per input beat (out_valid_o,
//   out_stall_i): 0 none, 1/2/3 single/double/triple click, 4 long press.
//   Configuration: cfg_we_i writes cfg_data_i into the register chosen by
//   cfg_index_i (0 long press ticks, 1 short click limit, 2 click gap ticks,
//   3 minimum press ticks); write only while the block is idle.
//   Result: the event of a beat appears in the cycle after it is accepted.
//   Throughput: one beat per cycle while the output is not stalled; the
//   whole state update is a single compare-and-count step between the
//   state registers and the result register.
//   Stall: while a result waits and out_stall_i is high, in_stall_o is high;
//   the result register frees itself in the cycle the result is taken, so a
//   new beat is accepted in that same cycle.
//   Reset: counters, pending clicks and the output valid clear; the
//   thresholds return to 120, 40, 25 and 2.
// -----------------------------------------------------------------------------
module button_click_classifier #(
  parameter int unsigned COUNT_WIDTH = bcc_pkg::CountWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               key_down_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bcc_pkg::EventWidth-1:0]     event_code_o,
  input  logic                               cfg_we_i,
  input  logic [bcc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [bcc_pkg::CfgWidth-1:0]       cfg_data_i
);
  import bcc_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  logic [CfgWidth-1:0] long_press_q, short_click_q, click_gap_q, min_press_q;

  logic [COUNT_WIDTH-1:0] press_count_q, press_count_d;
  logic [COUNT_WIDTH-1:0] gap_count_q, gap_count_d;
  logic [TallyWidth-1:0]  click_tally_q, click_tally_d;
  logic                   long_fired_q, long_fired_d;
  event_e                 event_q, event_d;
  logic                   out_valid_q, out_valid_d;

  logic                   accept;
  logic [COUNT_WIDTH-1:0] press_inc, gap_a, gap_inc;
  logic [TallyWidth-1:0]  tally_a;
  logic                   click_ok;

  assign in_stall_o   = out_valid_q && out_stall_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign event_code_o = event_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q  <= LongPressReset;
      short_click_q <= ShortClickReset;
      click_gap_q   <= ClickGapReset;
      min_press_q   <= MinPressReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LONG_PRESS:  long_press_q  <= cfg_data_i;
        CFG_SHORT_CLICK: short_click_q <= cfg_data_i;
        CFG_CLICK_GAP:   click_gap_q   <= cfg_data_i;
        CFG_MIN_PRESS:   min_press_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    press_inc = (press_count_q == CntMax) ? CntMax : press_count_q + 1'b1;
    click_ok  = (CmpW'(press_count_q) > CmpW'(min_press_q)) &&
                (CmpW'(press_count_q) < CmpW'(short_click_q)) && !long_fired_q;
    tally_a   = click_tally_q;
    if (click_ok && click_tally_q != TallyMax) begin
      tally_a = click_tally_q + 1'b1;
    end
    gap_a     = click_ok ? '0 : gap_count_q;
    gap_inc   = (gap_a == CntMax) ? CntMax : gap_a + 1'b1;

    press_count_d = press_count_q;
    gap_count_d   = gap_count_q;
    click_tally_d = click_tally_q;
    long_fired_d  = long_fired_q;
    event_d       = EV_NONE;

    if (key_down_i) begin
      press_count_d = press_inc;
      gap_count_d   = '0;
      if (CmpW'(press_inc) >= CmpW'(long_press_q) && !long_fired_q) begin
        long_fired_d  = 1'b1;
        click_tally_d = '0;
        event_d       = EV_LONG;
      end
    end else begin
      press_count_d = '0;
      long_fired_d  = 1'b0;
      click_tally_d = tally_a;
      gap_count_d   = gap_a;
      if (tally_a != '0) begin
        if (CmpW'(gap_inc) >= CmpW'(click_gap_q)) begin
          event_d       = event_e'({1'b0, tally_a});
          click_tally_d = '0;
          gap_count_d   = '0;
        end else begin
          gap_count_d = gap_inc;
        end
      end
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_count_q <= '0;
      gap_count_q   <= '0;
      click_tally_q <= '0;
      long_fired_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        press_count_q <= press_count_d;
        gap_count_q   <= gap_count_d;
        click_tally_q <= click_tally_d;
        long_fired_q  <= long_fired_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_q <= event_d;
    end
  end

`ifndef SYNTHESIS
  a_long_hold_no_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_fired_q |-> (click_tally_q == '0))
    else $error("pending clicks while a long press is held");

  a_gap_only_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gap_count_q != '0) |-> (press_count_q == '0))
    else $error("gap counter running while key is held");

  a_long_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_fired_q |-> (press_count_q != '0))
    else $error("long press flag set without a held press");
`endif

endmodule
